FILE: design/rwcp_pkg.sv
`default_nettype none

package rwcp_pkg;

  localparam logic [2:0] PH_RIFF  = 3'd0;
  localparam logic [2:0] PH_CHUNK = 3'd1;
  localparam logic [2:0] PH_FMT   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_SKIP  = 3'd4;
  localparam logic [2:0] PH_PAD   = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  localparam logic [31:0] TAG_FMT      = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
  localparam logic [15:0] PCM_TAG      = 16'h0001;
  localparam logic [31:0] DEFAULT_RATE = 32'd22050;
  localparam logic [1:0]  FMT_MONO16   = 2'd1;
  localparam logic [15:0] DEPTH_16     = 16'd16;
  localparam logic [15:0] DEPTH_8      = 16'd8;
  localparam logic [15:0] FMT_MIN_LEN  = 16'd16;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        last;
    logic        size_underflow;
    logic [31:0] data_bytes;
    logic [31:0] sample_rate;
    logic [1:0]  format_code;
    logic [15:0] sample;
    logic        kind;
  } res_t;

endpackage

`default_nettype wire

FILE: design/riff_wave_chunk_parser.sv
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata byte_in, tuser first_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata/tuser/tlast result items
//
// One request is parsed per clock when ready; the parse state updates in the cycle it is accepted.
// Each request gives zero, one or two results, held in a three-entry result queue.
// The input is ready while the queue holds at most one result, so the cycle after a
// request that gives two results takes no request, and the input also waits whenever
// a stalled output side leaves two results queued.
// Reset clears the parse state and the queue; first_byte restarts the parse.
module riff_wave_chunk_parser
  import rwcp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] byte_in
  input  wire logic [0:0]  s_axis_tuser,  // [0] first_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,  // [15:0] sample, [17:16] format_code,
                                          // [49:18] sample_rate, [81:50] data_bytes,
                                          // [82] size_underflow, [87:83] zero
  output logic [0:0]       m_axis_tuser,  // [0] kind
  output logic             m_axis_tlast
);

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  fc_q, fc_d;
  logic [32:0] rr_q, rr_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [15:0] ftag_q, ftag_d;
  logic [15:0] chan_q, chan_d;
  logic [15:0] depth_q, depth_d;
  logic [31:0] rate_q, rate_d;
  logic [1:0]  fmt_q, fmt_d;
  logic [31:0] size_q, size_d;
  logic [7:0]  hold_q, hold_d;

  logic        in_fire;
  logic [7:0]  b;
  logic        smp_v, sum_v, sum_uf;
  logic [15:0] smp_val;
  logic        do_body_end, do_chunk_end;
  logic [32:0] padded;
  logic [32:0] len_pad;
  logic [33:0] need;
  logic [31:0] left_dec;
  res_t        res0, res1;
  logic [1:0]  push_n;

  res_t        q_mem [3];
  logic [1:0]  wr_q, rd_q, cnt_q;
  logic [1:0]  wr1;
  logic        pop;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign b       = s_axis_tdata;

  always_comb begin
    phase_d = phase_q; fc_d = fc_q; rr_d = rr_q; tag_d = tag_q; len_d = len_q;
    left_d = left_q; ftag_d = ftag_q; chan_d = chan_q; depth_d = depth_q;
    rate_d = rate_q; fmt_d = fmt_q; size_d = size_q; hold_d = hold_q;
    smp_v = 1'b0; smp_val = '0; sum_v = 1'b0; sum_uf = 1'b0;
    do_body_end = 1'b0; do_chunk_end = 1'b0;
    padded = '0; len_pad = '0; need = '0;
    left_dec = left_q - 32'd1;
    if (in_fire) begin
      if (s_axis_tuser[0]) begin
        phase_d = PH_RIFF; fc_d = '0; rr_d = '0; tag_d = '0; len_d = '0;
        left_d = '0; ftag_d = '0; chan_d = '0; depth_d = '0;
        rate_d = DEFAULT_RATE; fmt_d = FMT_MONO16; size_d = '0; hold_d = '0;
      end
      left_dec = left_d - 32'd1;
      case (phase_d)
        PH_RIFF: begin
          if (fc_d >= 5'd4 && fc_d <= 5'd7) begin
            rr_d[{fc_d[1:0], 3'b000} +: 8] = b;
          end
          fc_d = fc_d + 5'd1;
          if (fc_d == 5'd12) begin
            padded = (rr_d + 33'd1) & ~33'd1;
            if (padded < 33'd4) begin
              sum_v = 1'b1; sum_uf = 1'b1; phase_d = PH_DONE;
            end else begin
              rr_d = padded - 33'd4;
              if (rr_d == '0) begin
                sum_v = 1'b1; phase_d = PH_DONE;
              end else begin
                phase_d = PH_CHUNK; fc_d = '0;
              end
            end
          end
        end
        PH_CHUNK: begin
          if (fc_d < 5'd4) begin
            if (fc_d == 5'd0) tag_d = {24'd0, b};
            else tag_d[{fc_d[1:0], 3'b000} +: 8] = b;
          end else begin
            if (fc_d == 5'd4) len_d = {24'd0, b};
            else len_d[{fc_d[1:0], 3'b000} +: 8] = b;
          end
          fc_d = fc_d + 5'd1;
          if (fc_d == 5'd8) begin
            left_d = len_d; fc_d = '0; hold_d = '0;
            if (tag_d == TAG_FMT) begin
              phase_d = PH_FMT;
            end else if (tag_d == TAG_DATA && ftag_d == PCM_TAG) begin
              phase_d = PH_DATA; size_d = len_d;
            end else begin
              phase_d = PH_SKIP;
            end
            if (len_d == '0) do_body_end = 1'b1;
          end
        end
        PH_FMT: begin
          if (len_d >= {16'd0, FMT_MIN_LEN} && fc_d < 5'd16) begin
            case (fc_d)
              5'd0:  ftag_d[7:0]   = b;
              5'd1:  ftag_d[15:8]  = b;
              5'd2:  chan_d[7:0]   = b;
              5'd3:  chan_d[15:8]  = b;
              5'd4, 5'd5, 5'd6, 5'd7: begin
                if (ftag_d == PCM_TAG) rate_d[{fc_d[1:0], 3'b000} +: 8] = b;
              end
              5'd14: depth_d[7:0]  = b;
              5'd15: begin
                depth_d[15:8] = b;
                if (ftag_d == PCM_TAG) begin
                  fmt_d = {chan_d != 16'd1, depth_d != DEPTH_8};
                end
              end
              default: ;
            endcase
            fc_d = fc_d + 5'd1;
          end
          left_d = left_dec;
          if (left_d == '0) do_body_end = 1'b1;
        end
        PH_DATA: begin
          if (depth_d == DEPTH_16) begin
            if (fc_d == 5'd0) begin
              hold_d = b; fc_d = 5'd1;
              if (left_d == 32'd1) begin
                smp_v = 1'b1; smp_val = {8'd0, b};
              end
            end else begin
              smp_v = 1'b1; smp_val = {b, hold_d}; fc_d = '0;
            end
          end else begin
            smp_v = 1'b1; smp_val = {8'd0, b};
          end
          left_d = left_dec;
          if (left_d == '0) do_body_end = 1'b1;
        end
        PH_SKIP: begin
          left_d = left_dec;
          if (left_d == '0) do_body_end = 1'b1;
        end
        PH_PAD: do_chunk_end = 1'b1;
        default: ;
      endcase
      if (do_body_end) begin
        if (len_d[0]) phase_d = PH_PAD;
        else do_chunk_end = 1'b1;
      end
      if (do_chunk_end) begin
        len_pad = ({1'b0, len_d} + 33'd1) & ~33'd1;
        need = {1'b0, len_pad} + 34'd8;
        if (need > {1'b0, rr_d}) begin
          sum_v = 1'b1; sum_uf = 1'b1; phase_d = PH_DONE;
        end else begin
          rr_d = rr_d - need[32:0];
          if (rr_d == '0) begin
            sum_v = 1'b1; phase_d = PH_DONE;
          end else begin
            phase_d = PH_CHUNK; fc_d = '0;
          end
        end
      end
    end
  end

  always_comb begin
    res_t s_item, m_item;
    s_item = '0;
    s_item.kind = KIND_SAMPLE;
    s_item.sample = smp_val;
    s_item.last = !sum_v;
    m_item = '0;
    m_item.kind = KIND_SUMMARY;
    m_item.format_code = fmt_d;
    m_item.sample_rate = rate_d;
    m_item.data_bytes = size_d;
    m_item.size_underflow = sum_uf;
    m_item.last = 1'b1;
    res0 = smp_v ? s_item : m_item;
    res1 = m_item;
    push_n = {1'b0, smp_v} + {1'b0, sum_v};
  end

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = cnt_q <= 2'd1;
  assign m_axis_tvalid = cnt_q != 2'd0;
  assign wr1           = (wr_q == 2'd2) ? 2'd0 : wr_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF; fc_q <= '0; rr_q <= '0; tag_q <= '0; len_q <= '0;
      left_q <= '0; ftag_q <= '0; chan_q <= '0; depth_q <= '0;
      rate_q <= DEFAULT_RATE; fmt_q <= FMT_MONO16; size_q <= '0; hold_q <= '0;
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      phase_q <= phase_d; fc_q <= fc_d; rr_q <= rr_d; tag_q <= tag_d; len_q <= len_d;
      left_q <= left_d; ftag_q <= ftag_d; chan_q <= chan_d; depth_q <= depth_d;
      rate_q <= rate_d; fmt_q <= fmt_d; size_q <= size_d; hold_q <= hold_d;
      cnt_q <= cnt_q + push_n - {1'b0, pop};
      if (pop) rd_q <= (rd_q == 2'd2) ? 2'd0 : rd_q + 2'd1;
      if (push_n == 2'd1) wr_q <= wr1;
      else if (push_n == 2'd2) wr_q <= (wr1 == 2'd2) ? 2'd0 : wr1 + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) q_mem[wr_q] <= res0;
    if (push_n == 2'd2) q_mem[wr1] <= res1;
  end

  always_comb begin
    res_t h;
    h = q_mem[rd_q];
    m_axis_tdata = {5'd0, h.size_underflow, h.data_bytes, h.sample_rate,
                    h.format_code, h.sample};
    m_axis_tuser = h.kind;
    m_axis_tlast = h.last;
  end

endmodule

`default_nettype wire
